// ===== hdl/crpc_pkg.sv =====
// ----------------------------------------------------------------------------
// crpc_pkg
// Shared types and constants of the cache read port controller.
// ----------------------------------------------------------------------------
package crpc_pkg;

  localparam int unsigned BANKS_DEFAULT    = 4;
  localparam int unsigned WIDE_BUS_DEFAULT = 1;
  localparam logic [31:0] WIDE_MASK        = 32'h0000_0004;

  // one registered input word, bank index already folded in
  typedef struct packed {
    logic [2:0]  request_kind;
    logic [31:0] address;
    logic        buffer_bank_valid;
    logic [31:0] buffer_address;
    logic        bus_busy;
    logic [2:0]  buffer_access;
    logic [2:0]  grants;
    logic        tag_valid;
    logic [2:0]  tag_access;
    logic        snoop_strobe;
    logic [31:0] snoop_address;
    logic [1:0]  bank;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0] bank_select;
    logic       bank_read;
    logic       tag_read;
    logic [1:0] bus_operation;
    logic       bus_request;
    logic       data_from_bank;
    logic [2:0] access_bits;
    logic       cond_store_ok;
    logic       ack;
  } result_t;

endpackage

// ===== hdl/crpc_bank_index.sv =====
// ----------------------------------------------------------------------------
// crpc_bank_index
// Bank of an address: (address >> 2) mod BANKS, folded nibble by nibble
// through constant residue tables.
// ----------------------------------------------------------------------------
module crpc_bank_index #(
  parameter int unsigned BANKS = crpc_pkg::BANKS_DEFAULT
) (
  input  logic [31:0] address_i,
  output logic [1:0]  bank_o
);

  localparam int unsigned NIBBLES = 8;

  logic [31:0] word;
  logic [3:0]  part_tbl [NIBBLES][16];
  logic [3:0]  fold_tbl [128];
  logic [6:0]  sum;

  assign word = {2'b00, address_i[31:2]};

  for (genvar i = 0; i < NIBBLES; i++) begin : g_nib
    localparam int unsigned WEIGHT = (1 << (4 * i)) % BANKS;
    for (genvar n = 0; n < 16; n++) begin : g_val
      localparam int unsigned RES = (n * WEIGHT) % BANKS;
      assign part_tbl[i][n] = 4'(RES);
    end
  end

  for (genvar s = 0; s < 128; s++) begin : g_fold
    localparam int unsigned RES = s % BANKS;
    assign fold_tbl[s] = 4'(RES);
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      sum = sum + 7'(part_tbl[i][word[4*i +: 4]]);
    end
  end

  assign bank_o = fold_tbl[sum][1:0];

endmodule

// ===== hdl/crpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// crpc_ctrl
// Port state machine, selected bank, access bits and reservation link.
// ----------------------------------------------------------------------------
module crpc_ctrl #(
  parameter int unsigned WIDE_BUS = crpc_pkg::WIDE_BUS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  crpc_pkg::item_t     item_i,
  output crpc_pkg::result_t   result_o
);

  localparam logic [2:0] ST_IDLE          = 3'd0;
  localparam logic [2:0] ST_DIRECT_WAIT   = 3'd1;
  localparam logic [2:0] ST_READ_TAG      = 3'd2;
  localparam logic [2:0] ST_READ_BANK     = 3'd3;
  localparam logic [2:0] ST_MISS_WAIT     = 3'd4;
  localparam logic [2:0] ST_MISS_REQ_TAG  = 3'd5;
  localparam logic [2:0] ST_MISS_READ_TAG = 3'd6;
  localparam logic [2:0] ST_MISS_REPLACE  = 3'd7;

  localparam logic [1:0] OP_NOTHING = 2'd0;
  localparam logic [1:0] OP_DIRECT  = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;

  localparam logic [2:0] KIND_CACHED     = 3'd1;
  localparam logic [2:0] KIND_DIRECT     = 3'd2;
  localparam logic [2:0] KIND_CACHED_RES = 3'd3;
  localparam logic [2:0] KIND_DIRECT_RES = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [1:0]  bank_q, bank_d;
  logic [2:0]  acc_q, acc_d;
  logic [31:0] link_q, link_d;
  logic        link_valid_q, link_valid_d;

  logic        rd, direct, lres, g_tag, g_bank, g_bus, hit;
  logic [31:0] cmp_adr;

  assign rd = (item_i.request_kind == KIND_CACHED) || (item_i.request_kind == KIND_DIRECT) ||
              (item_i.request_kind == KIND_CACHED_RES) ||
              (item_i.request_kind == KIND_DIRECT_RES);
  assign direct = (item_i.request_kind == KIND_DIRECT) ||
                  (item_i.request_kind == KIND_DIRECT_RES);
  assign lres = (item_i.request_kind == KIND_CACHED_RES) ||
                (item_i.request_kind == KIND_DIRECT_RES);
  assign g_tag  = item_i.grants[0];
  assign g_bank = item_i.grants[1];
  assign g_bus  = item_i.grants[2];
  assign cmp_adr = (WIDE_BUS != 0) ? (item_i.address & ~crpc_pkg::WIDE_MASK) : item_i.address;
  assign hit = item_i.buffer_bank_valid && (cmp_adr == item_i.buffer_address);

  always_comb begin
    state_d      = state_q;
    bank_d       = bank_q;
    acc_d        = acc_q;
    link_d       = link_q;
    link_valid_d = link_valid_q;
    result_o                = '0;
    result_o.bus_operation  = OP_NOTHING;
    result_o.cond_store_ok  = link_valid_q && (link_q == item_i.address);
    result_o.access_bits    = acc_q;
    result_o.data_from_bank = (state_q == ST_READ_BANK);
    result_o.bank_select    = bank_q;

    case (state_q)
      ST_IDLE: begin
        result_o.bus_operation = OP_DIRECT;
        if (rd) begin
          if (direct) begin
            result_o.bus_request = 1'b1;
            state_d = ST_DIRECT_WAIT;
          end else if (hit) begin
            acc_d = item_i.buffer_access;
            result_o.ack = 1'b1;
          end else begin
            result_o.tag_read = 1'b1;
            if (g_tag) state_d = ST_READ_TAG;
          end
          if (lres) begin
            link_d       = item_i.address;
            link_valid_d = 1'b1;
          end
        end
      end
      ST_DIRECT_WAIT: begin
        result_o.bus_operation = OP_DIRECT;
        result_o.bus_request   = !hit;
        if (hit) begin
          acc_d = item_i.buffer_access;
          result_o.ack = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ_TAG: begin
        result_o.tag_read  = 1'b1;
        result_o.bank_read = 1'b1;
        acc_d = item_i.tag_access;
        if (item_i.tag_valid) begin
          if (g_bank) begin
            result_o.ack = 1'b1;
            bank_d  = item_i.bank;
            state_d = ST_READ_BANK;
          end
        end else begin
          state_d = ST_MISS_WAIT;
        end
      end
      ST_READ_BANK: begin
        state_d = ST_IDLE;
        if (rd) begin
          if (direct) begin
            result_o.bus_operation = OP_DIRECT;
            result_o.bus_request   = 1'b1;
            state_d = ST_DIRECT_WAIT;
          end else if (hit) begin
            acc_d = item_i.buffer_access;
            result_o.ack = 1'b1;
          end else begin
            result_o.tag_read = 1'b1;
            state_d = ST_READ_TAG;
          end
        end
      end
      ST_MISS_WAIT: begin
        result_o.bus_request = 1'b1;
        if (hit) begin
          acc_d = item_i.buffer_access;
          result_o.ack = 1'b1;
          state_d = ST_IDLE;
        end else if (g_bus && !item_i.bus_busy) begin
          state_d = ST_MISS_REQ_TAG;
        end
      end
      ST_MISS_REQ_TAG: begin
        result_o.bus_request = 1'b1;
        result_o.tag_read    = 1'b1;
        if (g_tag) state_d = ST_MISS_READ_TAG;
      end
      ST_MISS_READ_TAG: begin
        result_o.bus_request = 1'b1;
        result_o.tag_read    = 1'b1;
        if (g_tag) begin
          result_o.bank_read = 1'b1;
          acc_d = item_i.tag_access;
          if (item_i.tag_valid) begin
            if (g_bank) begin
              bank_d  = item_i.bank;
              result_o.ack = 1'b1;
              state_d = ST_READ_BANK;
            end
          end else begin
            state_d = ST_MISS_REPLACE;
          end
        end
      end
      default: begin
        result_o.bus_request   = 1'b1;
        result_o.bus_operation = OP_REPLACE;
        if (hit) begin
          acc_d = item_i.buffer_access;
          result_o.ack = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase

    // snooped write to the linked address drops the reservation
    if (item_i.snoop_strobe && (item_i.snoop_address == link_d)) link_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bank_q       <= '0;
      acc_q        <= '0;
      link_q       <= '0;
      link_valid_q <= 1'b0;
    end else if (step_i) begin
      state_q      <= state_d;
      bank_q       <= bank_d;
      acc_q        <= acc_d;
      link_q       <= link_d;
      link_valid_q <= link_valid_d;
    end
  end

endmodule

// ===== hdl/cache_read_port_controller.sv =====
// ----------------------------------------------------------------------------
// cache_read_port_controller
// Cache read port control: one input word per port clock unless m_axis_tready stalls, one result word.
// an accepted word waits in the input register, its result word then in the result register
// throughput: one word per cycle while the result side is not stalled, the state machine steps once per word
// the result register frees the input side while a result waits to be taken, if the input register is empty
// reset: asynchronous, clears the state machine, bank, access bits and link
// ----------------------------------------------------------------------------
module cache_read_port_controller #(
  parameter int unsigned BANKS    = crpc_pkg::BANKS_DEFAULT,
  parameter int unsigned WIDE_BUS = crpc_pkg::WIDE_BUS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // address, buffer_bank_valid, buffer_address, bus_busy, buffer_access,
  // grants, tag_valid, tag_access, snoop_strobe, snoop_address, zero fill
  input  logic [111:0] s_axis_tdata,
  // request_kind
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ack, cond_store_ok, access_bits, data_from_bank, bus_request,
  // bus_operation, tag_read, bank_read, bank_select, zero fill
  output logic [15:0]  m_axis_tdata
);

  logic               in_valid_q, in_valid_d;
  crpc_pkg::item_t    in_q, in_d;
  logic               out_valid_q, out_valid_d;
  crpc_pkg::result_t  out_q, result;
  logic               advance, step;
  logic [1:0]         bank;

  crpc_bank_index #(
    .BANKS(BANKS)
  ) u_bank_index (
    .address_i(s_axis_tdata[31:0]),
    .bank_o   (bank)
  );

  always_comb begin
    in_d.request_kind      = s_axis_tuser;
    in_d.address           = s_axis_tdata[31:0];
    in_d.buffer_bank_valid = s_axis_tdata[32];
    in_d.buffer_address    = s_axis_tdata[64:33];
    in_d.bus_busy          = s_axis_tdata[65];
    in_d.buffer_access     = s_axis_tdata[68:66];
    in_d.grants            = s_axis_tdata[71:69];
    in_d.tag_valid         = s_axis_tdata[72];
    in_d.tag_access        = s_axis_tdata[75:73];
    in_d.snoop_strobe      = s_axis_tdata[76];
    in_d.snoop_address     = s_axis_tdata[108:77];
    in_d.bank              = bank;
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d   = advance ? in_valid_q : out_valid_q;

  crpc_ctrl #(
    .WIDE_BUS(WIDE_BUS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_q <= in_d;
    if (step) out_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

endmodule

// ===== bench/tb_cache_read_port_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cache_read_port_controller
// Self-checking bench for the cache read port controller. A directed run walks
// the uncached, buffer-hit, cache-hit and miss/refill paths and the link
// reservation, then 400 random words follow. Both stream sides
// idle at random. Every result word is checked field by field against a cycle
// predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_cache_read_port_controller;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam logic [31:0] ADR_WIDE_BIT = 32'h0000_0004;

  localparam logic [2:0] G_NONE = 3'b000;
  localparam logic [2:0] G_TAG  = 3'b001;
  localparam logic [2:0] G_BANK = 3'b010;
  localparam logic [2:0] G_BUS  = 3'b100;

  typedef enum logic [2:0] {
    RK_NONE, RK_CACHED, RK_UNCACHED, RK_CACHED_LINK, RK_UNCACHED_LINK,
    RK_RSVD5, RK_RSVD6, RK_RSVD7
  } req_kind_e;

  typedef enum logic [2:0] {
    PS_IDLE, PS_UNCACHED, PS_TAG, PS_BANK, PS_MISS_WAIT, PS_MISS_TAG_REQ,
    PS_MISS_TAG, PS_REFILL
  } port_state_e;

  typedef enum logic [1:0] {
    BOP_NONE, BOP_UNCACHED, BOP_REFILL
  } bus_op_e;

  class read_port_tracker;
    port_state_e         state;
    logic [1:0]          bank_reg;
    logic [31:0]         link_addr;
    logic                link_ok;
    logic [2:0]          acc_reg;
    crpc_pkg::result_t   due_q[$];
    int unsigned         errors;

    function new();
      state     = PS_IDLE;
      bank_reg  = '0;
      link_addr = '0;
      link_ok   = 1'b0;
      acc_reg   = '0;
      errors    = 0;
    endfunction

    function int pending_count();
      return due_q.size();
    endfunction

    // one port clock: outputs from the current state, then the register update
    function crpc_pkg::result_t step_port(crpc_pkg::item_t w);
      crpc_pkg::result_t r;
      logic        rd, unc, lnk, hit, g_tag, g_bank, g_bus;
      logic [1:0]  bnk, nbank;
      logic [2:0]  nacc;
      logic [31:0] nlink;
      logic        nvalid;
      port_state_e nst;
      rd     = w.request_kind >= RK_CACHED && w.request_kind <= RK_UNCACHED_LINK;
      unc    = w.request_kind == RK_UNCACHED || w.request_kind == RK_UNCACHED_LINK;
      lnk    = w.request_kind == RK_CACHED_LINK || w.request_kind == RK_UNCACHED_LINK;
      g_tag  = (w.grants & G_TAG) != 0;
      g_bank = (w.grants & G_BANK) != 0;
      g_bus  = (w.grants & G_BUS) != 0;
      bnk    = w.address[3:2];
      hit    = w.buffer_bank_valid && ((w.address & ~ADR_WIDE_BIT) == w.buffer_address);
      r                = '0;
      r.bus_operation  = BOP_NONE;
      r.cond_store_ok  = link_ok && link_addr == w.address;
      r.access_bits    = acc_reg;
      r.data_from_bank = state == PS_BANK;
      r.bank_select    = bank_reg;
      nst    = state;
      nbank  = bank_reg;
      nacc   = acc_reg;
      nlink  = link_addr;
      nvalid = link_ok;
      case (state)
        PS_IDLE: begin
          r.bus_operation = BOP_UNCACHED;
          if (rd) begin
            if (unc) begin
              r.bus_request = 1'b1;
              nst = PS_UNCACHED;
            end else if (hit) begin
              nacc = w.buffer_access;
              r.ack = 1'b1;
            end else begin
              r.tag_read = 1'b1;
              if (g_tag) nst = PS_TAG;
            end
            if (lnk) begin
              nlink  = w.address;
              nvalid = 1'b1;
            end
          end
        end
        PS_UNCACHED: begin
          r.bus_operation = BOP_UNCACHED;
          r.bus_request   = !hit;
          if (hit) begin
            nacc  = w.buffer_access;
            r.ack = 1'b1;
            nst   = PS_IDLE;
          end
        end
        PS_TAG: begin
          r.tag_read  = 1'b1;
          r.bank_read = 1'b1;
          nacc = w.tag_access;
          if (w.tag_valid) begin
            if (g_bank) begin
              r.ack = 1'b1;
              nbank = bnk;
              nst   = PS_BANK;
            end
          end else begin
            nst = PS_MISS_WAIT;
          end
        end
        PS_BANK: begin
          nst = PS_IDLE;
          if (rd) begin
            if (unc) begin
              r.bus_operation = BOP_UNCACHED;
              r.bus_request   = 1'b1;
              nst = PS_UNCACHED;
            end else if (hit) begin
              nacc  = w.buffer_access;
              r.ack = 1'b1;
            end else begin
              r.tag_read = 1'b1;
              nst = PS_TAG;
            end
          end
        end
        PS_MISS_WAIT: begin
          r.bus_request = 1'b1;
          if (hit) begin
            nacc  = w.buffer_access;
            r.ack = 1'b1;
            nst   = PS_IDLE;
          end else if (g_bus && !w.bus_busy) begin
            nst = PS_MISS_TAG_REQ;
          end
        end
        PS_MISS_TAG_REQ: begin
          r.bus_request = 1'b1;
          r.tag_read    = 1'b1;
          if (g_tag) nst = PS_MISS_TAG;
        end
        PS_MISS_TAG: begin
          r.bus_request = 1'b1;
          r.tag_read    = 1'b1;
          if (g_tag) begin
            r.bank_read = 1'b1;
            nacc = w.tag_access;
            if (w.tag_valid) begin
              if (g_bank) begin
                nbank = bnk;
                r.ack = 1'b1;
                nst   = PS_BANK;
              end
            end else begin
              nst = PS_REFILL;
            end
          end
        end
        default: begin
          r.bus_request   = 1'b1;
          r.bus_operation = BOP_REFILL;
          if (hit) begin
            nacc  = w.buffer_access;
            r.ack = 1'b1;
            nst   = PS_IDLE;
          end
        end
      endcase
      // snoop is compared with the link as it stands after this cycle
      if (w.snoop_strobe && w.snoop_address == nlink) nvalid = 1'b0;
      state     = nst;
      bank_reg  = nbank;
      acc_reg   = nacc;
      link_addr = nlink;
      link_ok   = nvalid;
      return r;
    endfunction

    function void note_word(crpc_pkg::item_t w);
      due_q.push_back(step_port(w));
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(crpc_pkg::result_t got);
      crpc_pkg::result_t exp_r;
      if (due_q.size() == 0) begin
        $error("result word with none expected: %0h", got);
        errors++;
        return;
      end
      exp_r = due_q.pop_front();
      cmp_field("ack", exp_r.ack, got.ack);
      cmp_field("cond_store_ok", exp_r.cond_store_ok, got.cond_store_ok);
      cmp_field("access_bits", exp_r.access_bits, got.access_bits);
      cmp_field("data_from_bank", exp_r.data_from_bank, got.data_from_bank);
      cmp_field("bus_request", exp_r.bus_request, got.bus_request);
      cmp_field("bus_operation", exp_r.bus_operation, got.bus_operation);
      cmp_field("tag_read", exp_r.tag_read, got.tag_read);
      cmp_field("bank_read", exp_r.bank_read, got.bank_read);
      cmp_field("bank_select", exp_r.bank_select, got.bank_select);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;

  read_port_tracker  tracker = new();
  crpc_pkg::item_t   stim_words[$];
  logic [31:0]       cur_addr;
  req_kind_e         cur_kind;
  int unsigned       idle_cycles;

  cache_read_port_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tb_cache_read_port_controller: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic crpc_pkg::item_t compose_word(req_kind_e kind, logic [31:0] adr,
                                                   logic bvalid, logic [31:0] badr,
                                                   logic busy, logic [2:0] bacc,
                                                   logic [2:0] gr, logic tv, logic [2:0] tacc,
                                                   logic sstb, logic [31:0] sadr);
    crpc_pkg::item_t w;
    w                   = '0;
    w.request_kind      = kind;
    w.address           = adr;
    w.buffer_bank_valid = bvalid;
    w.buffer_address    = badr;
    w.bus_busy          = busy;
    w.buffer_access     = bacc;
    w.grants            = gr;
    w.tag_valid         = tv;
    w.tag_access        = tacc;
    w.snoop_strobe      = sstb;
    w.snoop_address     = sadr;
    return w;
  endfunction

  function automatic logic [111:0] pack_word(crpc_pkg::item_t w);
    return {3'b000, w.snoop_address, w.snoop_strobe, w.tag_access, w.tag_valid, w.grants,
            w.buffer_access, w.bus_busy, w.buffer_address, w.buffer_bank_valid, w.address};
  endfunction

  task automatic add_directed();
    stim_words.push_back(compose_word(RK_NONE, '0, 0, '0, 0, 0, G_NONE, 0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_RSVD5, '0, 0, '0, 0, 0, G_TAG, 0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_RSVD6, 32'h0000_1000, 0, '0, 0, 0, G_TAG, 0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_RSVD7, '1, 1, '1, 1, 3'h7, 3'h7, 1, 3'h7, 1, '1));
    // buffer hit, address bit 2 ignored on the wide bus
    stim_words.push_back(compose_word(RK_CACHED, '1, 1, 32'hFFFF_FFFB, 0, 3'h7, G_NONE,
                                      0, 0, 0, '0));
    // reservation set and snooped away in the same cycle
    stim_words.push_back(compose_word(RK_UNCACHED_LINK, 32'h0000_1000, 0, '0, 0, 0, G_NONE,
                                      0, 0, 1, 32'h0000_1000));
    stim_words.push_back(compose_word(RK_UNCACHED_LINK, 32'h0000_1000, 1, 32'h0000_1000, 0,
                                      3'h5, G_NONE, 0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED_LINK, 32'h0000_2008, 0, '0, 0, 0, G_TAG,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED_LINK, 32'h0000_2008, 0, '0, 0, 0, G_NONE,
                                      1, 3'h3, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED_LINK, 32'h0000_2008, 0, '0, 0, 0, G_BANK,
                                      1, 3'h6, 0, '0));
    // new miss from the bank state skips the tag grant
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 0, '0, 0, 0, G_NONE,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 0, '0, 0, 0, G_TAG,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 0, '0, 1, 0, G_BUS,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 0, '0, 0, 0, G_BUS,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 0, '0, 0, 0, G_NONE,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 0, '0, 0, 0, G_TAG,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 0, '0, 0, 0, G_TAG,
                                      0, 3'h1, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 0, '0, 0, 0, G_NONE,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_3000, 1, 32'h0000_3000, 0, 3'h2,
                                      G_NONE, 0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_UNCACHED, 32'h0000_2008, 0, '0, 0, 0, G_NONE,
                                      0, 0, 1, 32'h0000_2008));
    stim_words.push_back(compose_word(RK_UNCACHED, 32'h0000_2008, 1, 32'h0000_2008, 0, 3'h4,
                                      G_NONE, 0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_4004, 0, '0, 0, 0, G_TAG,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_CACHED, 32'h0000_4004, 0, '0, 0, 0, G_TAG | G_BANK,
                                      1, 3'h4, 0, '0));
    stim_words.push_back(compose_word(RK_UNCACHED, 32'h0000_5000, 0, '0, 0, 0, G_NONE,
                                      0, 0, 0, '0));
    stim_words.push_back(compose_word(RK_UNCACHED, 32'h0000_5000, 1, 32'h0000_5000, 0, 3'h6,
                                      G_NONE, 0, 0, 0, '0));
  endtask

  task automatic add_random(int unsigned count);
    crpc_pkg::item_t w;
    logic [31:0]     bases[3];
    bases = '{32'h0000_1000, 32'hFFFF_F000, 32'h8000_0040};
    cur_addr = $urandom;
    cur_kind = RK_CACHED;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise
        w = compose_word(req_kind_e'($urandom_range(0, 7)), $urandom, $urandom_range(0, 1),
                         $urandom, $urandom_range(0, 1), $urandom_range(0, 7),
                         $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 7),
                         $urandom_range(0, 1), $urandom);
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 3) == 0) cur_addr = $urandom;
          else cur_addr = bases[$urandom_range(0, 2)] + ($urandom_range(0, 7) << 2);
          cur_kind = req_kind_e'($urandom_range(1, 4));
        end
        w = compose_word(cur_kind, cur_addr, $urandom_range(0, 1), '0, $urandom_range(0, 3) == 0,
                         $urandom_range(0, 7), '0, $urandom_range(0, 1), $urandom_range(0, 7),
                         $urandom_range(0, 3) == 0, '0);
        if ($urandom_range(0, 2) == 0) w.request_kind = req_kind_e'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
          0, 1:    w.buffer_address = cur_addr & ~ADR_WIDE_BIT;
          2:       w.buffer_address = cur_addr;
          default: w.buffer_address = $urandom;
        endcase
        w.grants = {$urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                    $urandom_range(0, 3) != 0};
        w.snoop_address = $urandom_range(0, 1) ? cur_addr : $urandom;
      end
      stim_words.push_back(w);
    end
  endtask

  task automatic send_words();
    int unsigned gap;
    int unsigned pause_at;
    pause_at = stim_words.size() / 2;
    @(negedge clk_i);
    for (int i = 0; i < stim_words.size(); i++) begin
      gap = (i % 64 < 16) ? 0 : $urandom_range(0, 17);
      if (i == pause_at) gap = gap + 1;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        if (i == pause_at) begin
          while (tracker.pending_count() != 0) @(negedge clk_i);
        end
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pack_word(stim_words[i]);
      s_axis_tuser  <= stim_words[i].request_kind;
      do @(posedge clk_i); while (!s_axis_tready);
      tracker.note_word(stim_words[i]);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic take_results();
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    @(negedge clk_i);
    forever begin
      stall = (taken % 50 < 12) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_word(crpc_pkg::result_t'(m_axis_tdata[12:0]));
      taken++;
      @(negedge clk_i);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    idle_cycles   = 0;
    add_directed();
    add_random(RANDOM_WORDS);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    fork
      take_results();
    join_none
    send_words();
    while (tracker.pending_count() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (tracker.errors == 0) begin
      $display("tb_cache_read_port_controller: done, clean");
    end else begin
      $display("tb_cache_read_port_controller: done, errors");
    end
    $finish;
  end

endmodule
